FILE: hdl/rhp_pkg.sv
// rhp_pkg: shared types and constants for the RGB to HSV pixel converter.
// No dependencies.
package rhp_pkg;

  localparam int unsigned ChanW    = 16;
  localparam int unsigned HueW     = 19;
  localparam int unsigned SatW     = 17;
  localparam int unsigned RemW     = 17;
  localparam int unsigned QuoW     = 18;
  localparam int unsigned DivSteps = 18;

  localparam logic [HueW-1:0] HueTwo  = 19'h20000;
  localparam logic [HueW-1:0] HueFour = 19'h40000;
  localparam logic [HueW-1:0] HueSix  = 19'h60000;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        hue_div;
    div_lane_t        sat_div;
    logic [ChanW-1:0] gap;
    logic [ChanW-1:0] brightness;
    logic             neg;
    sector_t          sector;
    logic             grey;
  } work_t;

endpackage

FILE: hdl/rhp_pix_if.sv
// rhp_pix_if: valid/ready channel carrying one RGB pixel word.
// No dependencies.
interface rhp_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hdl/rhp_hsv_if.sv
// rhp_hsv_if: valid/ready channel carrying one HSV result word.
// No dependencies.
interface rhp_hsv_if;
  logic        valid;
  logic        ready;
  logic [18:0] hue;
  logic [16:0] saturation;
  logic [15:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink (input valid, input hue, input saturation, input brightness, output ready);
endinterface

FILE: hdl/rgb_to_hsv_pixel_top.sv
// rgb_to_hsv_pixel_top: RGB to HSV pixel converter, front stage, division cells, output stage.
// Depends on rhp_pkg, rhp_pix_if, rhp_hsv_if, rhp_front, rhp_cell, rhp_back.
//
// Takes one pixel word per clock when not stalled and returns one HSV word per pixel, in order.
// The stages are one front stage (max, min, sector), a row of 18
// restoring-division cells that each settle one quotient bit of hue and of
// saturation, and one output stage that rounds and holds the result. Every
// stage has its own valid bit, so bubbles are squeezed out and the input
// keeps taking words while the output is stalled until all stages are full.
// Throughput is one pixel per clock while the output does not stall.
module rgb_to_hsv_pixel_top (
  input  logic      clk,
  input  logic      rst,
  rhp_pix_if.sink   pix,
  rhp_hsv_if.source hsv
);

  rhp_pkg::work_t chain_d [0:rhp_pkg::DivSteps];
  logic           chain_v [0:rhp_pkg::DivSteps];
  logic           chain_r [0:rhp_pkg::DivSteps];

  rhp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .dout       (chain_d[0]),
    .dout_valid (chain_v[0]),
    .dout_ready (chain_r[0])
  );

  for (genvar i = 0; i < rhp_pkg::DivSteps; i++) begin : g_cell
    rhp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .din        (chain_d[i]),
      .din_valid  (chain_v[i]),
      .din_ready  (chain_r[i]),
      .dout       (chain_d[i+1]),
      .dout_valid (chain_v[i+1]),
      .dout_ready (chain_r[i+1])
    );
  end

  rhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .din       (chain_d[rhp_pkg::DivSteps]),
    .din_valid (chain_v[rhp_pkg::DivSteps]),
    .din_ready (chain_r[rhp_pkg::DivSteps]),
    .hsv       (hsv)
  );

endmodule

FILE: hdl/rhp_front.sv
// rhp_front: max/min, gap, sector pick and difference magnitude; first register stage.
// Depends on rhp_pkg and rhp_pix_if.
module rhp_front (
  input  logic           clk,
  input  logic           rst,
  rhp_pix_if.sink        pix,
  output rhp_pkg::work_t dout,
  output logic           dout_valid,
  input  logic           dout_ready
);

  logic [15:0]      vmax;
  logic [15:0]      vmin;
  logic [15:0]      gap;
  logic [15:0]      op_a;
  logic [15:0]      op_b;
  logic [15:0]      mag;
  logic             neg;
  rhp_pkg::sector_t sector;
  rhp_pkg::work_t   work;
  logic             valid;
  logic             load;

  always_comb begin
    vmax = pix.red;
    if (pix.green > vmax) vmax = pix.green;
    if (pix.blue > vmax) vmax = pix.blue;
    vmin = pix.red;
    if (pix.green < vmin) vmin = pix.green;
    if (pix.blue < vmin) vmin = pix.blue;
    gap = vmax - vmin;

    priority if (pix.red == vmax) begin
      sector = rhp_pkg::SECT_RED;
      op_a   = pix.green;
      op_b   = pix.blue;
    end else if (pix.green == vmax) begin
      sector = rhp_pkg::SECT_GREEN;
      op_a   = pix.blue;
      op_b   = pix.red;
    end else begin
      sector = rhp_pkg::SECT_BLUE;
      op_a   = pix.red;
      op_b   = pix.green;
    end

    neg = op_a < op_b;
    mag = neg ? (op_b - op_a) : (op_a - op_b);

    work.hue_div.rem = {1'b0, mag};
    work.hue_div.quo = '0;
    work.sat_div.rem = {1'b0, gap};
    work.sat_div.quo = '0;
    work.gap         = gap;
    work.brightness  = vmax;
    work.neg         = neg;
    work.sector      = sector;
    work.grey        = (gap == 16'd0);
  end

  assign pix.ready  = !valid || dout_ready;
  assign load       = pix.valid && pix.ready;
  assign dout_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pix.ready) begin
      valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= work;
    end
  end

endmodule

FILE: hdl/rhp_cell.sv
// rhp_cell: one restoring-division step for both the hue and saturation quotients.
// Depends on rhp_pkg.
module rhp_cell (
  input  logic           clk,
  input  logic           rst,
  input  rhp_pkg::work_t din,
  input  logic           din_valid,
  output logic           din_ready,
  output rhp_pkg::work_t dout,
  output logic           dout_valid,
  input  logic           dout_ready
);

  rhp_pkg::work_t step;
  logic           hue_ge;
  logic           sat_ge;
  logic [16:0]    hue_diff;
  logic [16:0]    sat_diff;
  logic           valid;

  always_comb begin
    step     = din;
    hue_ge   = din.hue_div.rem >= {1'b0, din.gap};
    hue_diff = din.hue_div.rem - (hue_ge ? {1'b0, din.gap} : 17'd0);
    sat_ge   = din.sat_div.rem >= {1'b0, din.brightness};
    sat_diff = din.sat_div.rem - (sat_ge ? {1'b0, din.brightness} : 17'd0);
    // remainder stays below the divisor, so the shift never loses a bit
    step.hue_div.rem = {hue_diff[15:0], 1'b0};
    step.hue_div.quo = {din.hue_div.quo[16:0], hue_ge};
    step.sat_div.rem = {sat_diff[15:0], 1'b0};
    step.sat_div.quo = {din.sat_div.quo[16:0], sat_ge};
  end

  assign din_ready  = !valid || dout_ready;
  assign dout_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (din_ready) begin
      valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din_valid && din_ready) begin
      dout <= step;
    end
  end

endmodule

FILE: hdl/rhp_back.sv
// rhp_back: rounds both quotients, forms hue by sector, holds the output word.
// Depends on rhp_pkg and rhp_hsv_if.
module rhp_back (
  input  logic           clk,
  input  logic           rst,
  input  rhp_pkg::work_t din,
  input  logic           din_valid,
  output logic           din_ready,
  rhp_hsv_if.source      hsv
);

  logic [17:0] hue_q1;
  logic [17:0] sat_q1;
  logic [16:0] hue_mag;
  logic [18:0] mag_ext;
  logic [18:0] hue_calc;
  logic [16:0] sat_calc;
  logic        valid;

  always_comb begin
    // quotient carries one extra fraction bit: round half away from zero
    hue_q1  = din.hue_div.quo + 18'd1;
    sat_q1  = din.sat_div.quo + 18'd1;
    hue_mag = hue_q1[17:1];
    mag_ext = {2'b00, hue_mag};

    unique case (din.sector)
      rhp_pkg::SECT_RED: begin
        if (!din.neg) hue_calc = mag_ext;
        else if (hue_mag == 17'd0) hue_calc = '0;
        else hue_calc = rhp_pkg::HueSix - mag_ext;
      end
      rhp_pkg::SECT_GREEN: begin
        hue_calc = din.neg ? (rhp_pkg::HueTwo - mag_ext) : (rhp_pkg::HueTwo + mag_ext);
      end
      rhp_pkg::SECT_BLUE: begin
        hue_calc = din.neg ? (rhp_pkg::HueFour - mag_ext) : (rhp_pkg::HueFour + mag_ext);
      end
      default: hue_calc = '0;
    endcase

    sat_calc = sat_q1[17:1];
    if (din.grey) begin
      hue_calc = '0;
      sat_calc = '0;
    end
  end

  assign din_ready = !valid || hsv.ready;
  assign hsv.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (din_ready) begin
      valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din_valid && din_ready) begin
      hsv.hue        <= hue_calc;
      hsv.saturation <= sat_calc;
      hsv.brightness <= din.brightness;
    end
  end

endmodule

FILE: hdl/rhp_checker.sv
// rhp_checker: port-level assertions for rgb_to_hsv_pixel_top, bound to the top level.
// Depends on rgb_to_hsv_pixel_top port names only.
module rhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        pix_ready,
  input logic        hsv_valid,
  input logic        hsv_ready,
  input logic [18:0] hsv_hue,
  input logic [16:0] hsv_saturation,
  input logic [15:0] hsv_brightness
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_ready |=> hsv_valid && $stable(hsv_hue)
      && $stable(hsv_saturation) && $stable(hsv_brightness))
    else $error("output word changed while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv_hue < 19'd393216)
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv_saturation <= 17'd65536)
    else $error("saturation above one");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv_saturation == 17'd0 |-> hsv_hue == 19'd0)
    else $error("grey pixel with nonzero hue");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !hsv_valid |-> pix_ready)
    else $error("input blocked with empty output");

endmodule

bind rgb_to_hsv_pixel_top rhp_checker u_rhp_checker (
  .clk            (clk),
  .rst            (rst),
  .pix_ready      (pix.ready),
  .hsv_valid      (hsv.valid),
  .hsv_ready      (hsv.ready),
  .hsv_hue        (hsv.hue),
  .hsv_saturation (hsv.saturation),
  .hsv_brightness (hsv.brightness)
);

FILE: test/tb_rgb_to_hsv_pixel_top.sv
// tb_rgb_to_hsv_pixel_top: self-checking bench for the RGB to HSV pixel converter.
// Depends on rhp_pkg, rhp_pix_if, rhp_hsv_if and rgb_to_hsv_pixel_top; drives
// pixel words, predicts each HSV word in order and checks it field by field.
module tb_rgb_to_hsv_pixel_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned RandomPixels  = 1100;
  localparam int unsigned MaxPrinted    = 50;

  typedef struct {
    logic [rhp_pkg::ChanW-1:0] red;
    logic [rhp_pkg::ChanW-1:0] green;
    logic [rhp_pkg::ChanW-1:0] blue;
    int unsigned               gap;
    bit                        drain;
    bit                        hold;
  } pix_job_t;

  typedef struct {
    logic [rhp_pkg::HueW-1:0]  hue;
    logic [rhp_pkg::SatW-1:0]  saturation;
    logic [rhp_pkg::ChanW-1:0] brightness;
  } hsv_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhp_pix_if pix ();
  rhp_hsv_if hsv ();

  rgb_to_hsv_pixel_top i_dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .hsv (hsv)
  );

  pix_job_t    pix_pending_q[$];
  hsv_word_t   hsv_expect_q[$];
  int unsigned pix_in_cnt      = 0;
  int unsigned hsv_out_cnt     = 0;
  int unsigned grey_cnt        = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned err_cnt         = 0;
  int unsigned hold_req        = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // round(num * 2^16 / den), ties away from zero
  function automatic longint unsigned q16_ratio(longint unsigned num, longint unsigned den);
    return ((num << 16) * 2 + den) / (den * 2);
  endfunction

  function automatic hsv_word_t predict_hsv(logic [rhp_pkg::ChanW-1:0] r,
                                            logic [rhp_pkg::ChanW-1:0] g,
                                            logic [rhp_pkg::ChanW-1:0] b);
    hsv_word_t         res;
    longint unsigned   vmax;
    longint unsigned   vmin;
    longint unsigned   gap;
    longint unsigned   pos;
    longint unsigned   neg;
    longint unsigned   offset;
    longint unsigned   q;
    longint unsigned   h;
    longint unsigned   s;
    rhp_pkg::sector_t  sect;
    vmax = r;
    vmin = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    gap = vmax - vmin;
    res.brightness = vmax[rhp_pkg::ChanW-1:0];
    res.hue        = '0;
    res.saturation = '0;
    if (gap != 0) begin
      if (r == vmax) sect = rhp_pkg::SECT_RED;
      else if (g == vmax) sect = rhp_pkg::SECT_GREEN;
      else sect = rhp_pkg::SECT_BLUE;
      case (sect)
        rhp_pkg::SECT_RED: begin
          pos = g; neg = b; offset = 0;
        end
        rhp_pkg::SECT_GREEN: begin
          pos = b; neg = r; offset = rhp_pkg::HueTwo;
        end
        default: begin
          pos = r; neg = g; offset = rhp_pkg::HueFour;
        end
      endcase
      if (pos >= neg) begin
        h = offset + q16_ratio(pos - neg, gap);
      end else begin
        q = q16_ratio(neg - pos, gap);
        if (sect == rhp_pkg::SECT_RED) begin
          h = rhp_pkg::HueSix - q;
          if (h >= rhp_pkg::HueSix) h = 0;
        end else begin
          h = offset - q;
        end
      end
      s = q16_ratio(gap, vmax);
      res.hue        = h[rhp_pkg::HueW-1:0];
      res.saturation = s[rhp_pkg::SatW-1:0];
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [rhp_pkg::ChanW-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      3: return 16'hfffe;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pix_job_t make_random_pixel();
    pix_job_t                  job;
    int unsigned               r;
    int unsigned               v;
    logic [rhp_pkg::ChanW-1:0] a;
    logic [rhp_pkg::ChanW-1:0] c;
    r = $urandom_range(99);
    job = '{default: 0};
    if (r < 55) begin
      job.red   = 16'($urandom_range(0, 65535));
      job.green = 16'($urandom_range(0, 65535));
      job.blue  = 16'($urandom_range(0, 65535));
    end else if (r < 70) begin
      a = 16'($urandom_range(0, 65535));
      c = 16'($urandom_range(0, 65535));
      case ($urandom_range(2))
        0: begin job.red = a; job.green = a; job.blue = c; end
        1: begin job.red = a; job.green = c; job.blue = a; end
        default: begin job.red = c; job.green = a; job.blue = a; end
      endcase
    end else if (r < 80) begin
      a = 16'($urandom_range(0, 65535));
      job.red   = a;
      job.green = a;
      job.blue  = a;
    end else if (r < 92) begin
      v = $urandom_range(0, 65535);
      job.red   = 16'(v - $urandom_range(0, (v < 4) ? v : 4));
      job.green = 16'(v - $urandom_range(0, (v < 4) ? v : 4));
      job.blue  = 16'(v - $urandom_range(0, (v < 4) ? v : 4));
    end else begin
      job.red   = pick_extreme();
      job.green = pick_extreme();
      job.blue  = pick_extreme();
    end
    return job;
  endfunction

  task automatic add_pixel(logic [rhp_pkg::ChanW-1:0] r, logic [rhp_pkg::ChanW-1:0] g,
                           logic [rhp_pkg::ChanW-1:0] b);
    pix_job_t job;
    job = '{default: 0};
    job.red   = r;
    job.green = g;
    job.blue  = b;
    job.gap   = pick_gap();
    pix_pending_q.push_back(job);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_cnt++;
    if (err_cnt <= MaxPrinted)
      $display("mismatch %s: got %0h expected %0h at word %0d", what, got, want, hsv_out_cnt);
  endtask

  // pixel driver
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    pix_job_t job;
    if (rst) begin
      pix.valid <= 1'b0;
      pix.red   <= '0;
      pix.green <= '0;
      pix.blue  <= '0;
      gap_left  <= 0;
    end else if (!(pix.valid && !pix.ready)) begin
      if (gap_left > 0) begin
        pix.valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pix_pending_q.size() > 0 &&
                   (!pix_pending_q[0].drain ||
                    (!pix.valid && pix_in_cnt == hsv_out_cnt))) begin
        job = pix_pending_q.pop_front();
        pix.valid <= 1'b1;
        pix.red   <= job.red;
        pix.green <= job.green;
        pix.blue  <= job.blue;
        gap_left  <= job.gap;
        if (job.hold) hold_req <= hold_req + 1;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // result side ready: random stalls in phases, plus long holds on request
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned phase_left = 0;
  int unsigned stall_pct  = 0;

  always @(posedge clk) begin
    if (rst) begin
      hsv.ready  <= 1'b0;
      hold_seen  <= 0;
      hold_left  <= 0;
      stall_left <= 0;
      phase_left <= 0;
      stall_pct  <= 0;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(50, 300);
        case ($urandom_range(2))
          0: stall_pct <= 0;
          1: stall_pct <= 15;
          default: stall_pct <= 50;
        endcase
      end else begin
        phase_left <= phase_left - 1;
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        hsv.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        hsv.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        hsv.ready  <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left <= pick_gap();
        hsv.ready  <= 1'b0;
      end else begin
        hsv.ready <= 1'b1;
      end
    end
  end

  // predictor and checker
  always @(posedge clk) begin
    hsv_word_t want;
    if (!rst) begin
      if (hsv.valid && hsv.ready) begin
        hsv_out_cnt <= hsv_out_cnt + 1;
        if (hsv_expect_q.size() == 0) begin
          report_mismatch("unexpected word, hue", hsv.hue, 0);
        end else begin
          want = hsv_expect_q.pop_front();
          if (hsv.hue !== want.hue) report_mismatch("hue", hsv.hue, want.hue);
          if (hsv.saturation !== want.saturation)
            report_mismatch("saturation", hsv.saturation, want.saturation);
          if (hsv.brightness !== want.brightness)
            report_mismatch("brightness", hsv.brightness, want.brightness);
        end
      end
      if (pix.valid && pix.ready) begin
        hsv_expect_q.push_back(predict_hsv(pix.red, pix.green, pix.blue));
        pix_in_cnt <= pix_in_cnt + 1;
        if (pix.red == pix.green && pix.green == pix.blue) grey_cnt <= grey_cnt + 1;
      end
      if (pix.valid && !pix.ready) in_stall_cycles <= in_stall_cycles + 1;
    end
  end

  // watchdog on cycles with no word moving
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (hsv.valid && hsv.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("rgb_to_hsv_pixel_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pix_job_t    job;
    int unsigned quiet_left;

    // directed: grey, primaries, ties, sector signs, tiny gaps
    add_pixel(16'h0000, 16'h0000, 16'h0000);
    add_pixel(16'hffff, 16'hffff, 16'hffff);
    add_pixel(16'h8000, 16'h8000, 16'h8000);
    add_pixel(16'hffff, 16'h0000, 16'h0000);
    add_pixel(16'h0000, 16'hffff, 16'h0000);
    add_pixel(16'h0000, 16'h0000, 16'hffff);
    add_pixel(16'hffff, 16'hffff, 16'h0000);
    add_pixel(16'h0000, 16'hffff, 16'hffff);
    add_pixel(16'hffff, 16'h0000, 16'hffff);
    add_pixel(16'hffff, 16'h0000, 16'h0001);
    add_pixel(16'hffff, 16'h0001, 16'h0000);
    add_pixel(16'h0001, 16'h0000, 16'h0000);
    add_pixel(16'h0000, 16'h0001, 16'h0000);
    add_pixel(16'h0000, 16'h0000, 16'h0001);
    add_pixel(16'h0002, 16'h0001, 16'h0000);
    add_pixel(16'h8000, 16'hffff, 16'h0000);
    add_pixel(16'h0000, 16'h8000, 16'hffff);
    add_pixel(16'hffff, 16'hfffe, 16'hfffe);
    add_pixel(16'h5555, 16'haaaa, 16'h0000);
    add_pixel(16'haaaa, 16'h5555, 16'hffff);
    add_pixel(16'h1234, 16'h5678, 16'h9abc);
    add_pixel(16'hffff, 16'h7fff, 16'h8000);

    quiet_left = 0;
    for (int unsigned i = 0; i < RandomPixels; i++) begin
      job = make_random_pixel();
      if (quiet_left == 0 && $urandom_range(99) < 3) quiet_left = $urandom_range(30, 80);
      if (i == 400 || i == 900) begin
        job.hold   = 1'b1;
        quiet_left = 60;
      end
      if (i == 0 || i == 650) job.drain = 1'b1;
      if (quiet_left > 0) begin
        job.gap = 0;
        quiet_left--;
      end else begin
        job.gap = pick_gap();
      end
      pix_pending_q.push_back(job);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pix_pending_q.size() != 0 || pix.valid || pix_in_cnt != hsv_out_cnt)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    while (hsv_expect_q.size() != 0) begin
      report_mismatch("missing word, brightness", 0, hsv_expect_q[0].brightness);
      void'(hsv_expect_q.pop_front());
    end

    $display("%0d pixels in, %0d HSV words checked, %0d grey pixels", pix_in_cnt,
             hsv_out_cnt, grey_cnt);
    $display("input held off for %0d cycles by output backpressure, %0d mismatches",
             in_stall_cycles, err_cnt);
    if (err_cnt == 0) begin
      $display("rgb_to_hsv_pixel_top test passed");
    end else begin
      $display("rgb_to_hsv_pixel_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/rhp_pkg.sv
hdl/rhp_pix_if.sv
hdl/rhp_hsv_if.sv
hdl/rhp_front.sv
hdl/rhp_cell.sv
hdl/rhp_back.sv
hdl/rgb_to_hsv_pixel_top.sv
hdl/rhp_checker.sv
test/tb_rgb_to_hsv_pixel_top.sv
